// ===== design/wf3_pkg.sv =====
// Shared types and constants for the 3x3 window filter.
package wf3_pkg;

    localparam int PX_W   = 8;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 11;
    localparam int CFG_W  = 13;
    localparam int IDX_W  = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_CNT_W = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_FILTER_MODE  = 2'd2;

    // Filter mode codes
    localparam logic [2:0] MODE_MEAN     = 3'd0;
    localparam logic [2:0] MODE_GAUSSIAN = 3'd1;
    localparam logic [2:0] MODE_LAPLACE  = 3'd2;
    localparam logic [2:0] MODE_ROBERTS  = 3'd3;
    localparam logic [2:0] MODE_SOBEL    = 3'd4;
    localparam logic [2:0] MODE_UNSHARP  = 3'd5;

    // floor(s/9) = (s * 7282) >> 16 for s up to 9*255
    localparam logic [12:0] RECIP9 = 13'd7282;

    // One emitting request handed from front to back.
    typedef struct packed {
        logic [2:0][2:0][PX_W-1:0] win;   // [raw row i-2..i][col j-2..j]
        logic [ROW_W-1:0]          row;   // current row i
        logic [COL_W-1:0]          col;   // current column j
        logic                      top;   // i == 1: mirror north row
        logic                      jf;    // j == 1: mirror west column
        logic                      lc;    // last column
        logic                      lr;    // last row
    } t_job;

endpackage

// ===== design/wf3_px_if.sv =====
// Input pixel channel.
interface wf3_px_if;
    logic                     valid;
    logic                     ready;
    logic [wf3_pkg::PX_W-1:0] pixel_in;
    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== design/wf3_res_if.sv =====
// Filtered result channel.
interface wf3_res_if;
    logic                      valid;
    logic                      ready;
    logic [wf3_pkg::PX_W-1:0]  pixel_out;
    logic [wf3_pkg::ROW_W-1:0] out_row;
    logic [wf3_pkg::COL_W-1:0] out_col;
    logic                      last_in_run;
    logic                      end_of_frame;
    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output last_in_run, output end_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input last_in_run, input end_of_frame, output ready);
endinterface

// ===== design/wf3_front.sv =====
// Front end: raster counters, line stores and window shift; queues jobs.
module wf3_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [11:0]                   i_frame_width,
    input  logic [12:0]                   i_frame_height,
    input  logic [wf3_pkg::FIFO_CNT_W-1:0] i_fifo_count,
    wf3_px_if.sink                        i_px,
    output logic                          o_push,
    output wf3_pkg::t_job                 o_job
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [7:0] r_ls_up [MAX_WIDTH];
    logic [7:0] r_ls_lo [MAX_WIDTH];
    logic [7:0] r_rd_up, r_rd_lo;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic          r_s0_valid;
    logic [7:0]    r_s0_px;
    logic [CW-1:0] r_s0_col;
    logic [RW-1:0] r_s0_row;
    logic          r_s0_emit, r_s0_top, r_s0_jf, r_s0_lc, r_s0_lr;

    logic [2:0][2:0][7:0] r_win, n_win;

    logic [CW:0] w_lim, w_m1;
    logic [RW:0] h_lim, h_m1;
    logic        accept, last_col, last_row;

    always_comb begin
        if (i_frame_width < 12'd2) begin
            w_lim = (CW+1)'(2);
        end else if (32'(i_frame_width) > MAX_WIDTH) begin
            w_lim = (CW+1)'(MAX_WIDTH);
        end else begin
            w_lim = (CW+1)'(i_frame_width);
        end
        if (i_frame_height < 13'd2) begin
            h_lim = (RW+1)'(2);
        end else if (32'(i_frame_height) > MAX_HEIGHT) begin
            h_lim = (RW+1)'(MAX_HEIGHT);
        end else begin
            h_lim = (RW+1)'(i_frame_height);
        end
        w_m1 = w_lim - (CW+1)'(1);
        h_m1 = h_lim - (RW+1)'(1);
    end

    assign last_col = {1'b0, r_col} >= w_m1;
    assign last_row = {1'b0, r_row} >= h_m1;

    // Room for the request in stage 0 and this one
    assign i_px.ready = ({1'b0, i_fifo_count} + {3'b0, r_s0_valid})
                        < (wf3_pkg::FIFO_CNT_W+1)'(wf3_pkg::FIFO_DEPTH);
    assign accept = i_px.valid & i_px.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s0_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_s0_valid <= accept;
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (r_s0_valid) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_px   <= i_px.pixel_in;
            r_s0_col  <= r_col;
            r_s0_row  <= r_row;
            r_s0_emit <= (r_row != '0) && (r_col != '0);
            r_s0_top  <= r_row == RW'(1);
            r_s0_jf   <= r_col == CW'(1);
            r_s0_lc   <= last_col;
            r_s0_lr   <= last_row;
        end
    end

    // Line stores: read on accept, rotate in the cycle after
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_up <= r_ls_up[r_col];
            r_rd_lo <= r_ls_lo[r_col];
        end
        if (r_s0_valid) begin
            r_ls_up[r_s0_col] <= r_rd_lo;
            r_ls_lo[r_s0_col] <= r_s0_px;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = r_rd_up;
        n_win[1][2] = r_rd_lo;
        n_win[2][2] = r_s0_px;
    end

    assign o_push    = r_s0_valid & r_s0_emit;
    assign o_job.win = n_win;
    assign o_job.row = wf3_pkg::ROW_W'(r_s0_row);
    assign o_job.col = wf3_pkg::COL_W'(r_s0_col);
    assign o_job.top = r_s0_top;
    assign o_job.jf  = r_s0_jf;
    assign o_job.lc  = r_s0_lc;
    assign o_job.lr  = r_s0_lr;
endmodule

// ===== design/wf3_fifo.sv =====
// Short job queue between front and back.
module wf3_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  wf3_pkg::t_job                  i_job,
    input  logic                           i_pop,
    output logic                           o_valid,
    output wf3_pkg::t_job                  o_job,
    output logic [wf3_pkg::FIFO_CNT_W-1:0] o_count
);
    localparam int AW = $clog2(wf3_pkg::FIFO_DEPTH);

    wf3_pkg::t_job r_mem [wf3_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [wf3_pkg::FIFO_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop)  r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];
    assign o_count = r_cnt;
endmodule

// ===== design/wf3_back.sv =====
// Back end: expands a job into its results and applies the filter.
module wf3_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [2:0]    i_mode,
    input  logic          i_job_valid,
    input  wf3_pkg::t_job i_job,
    output logic          o_pop,
    wf3_res_if.source     o_res
);
    typedef enum logic [1:0] {PH_UN, PH_UE, PH_BN, PH_BE} t_phase;

    t_phase r_phase, n_phase;
    logic   r_ov;
    logic [7:0]  r_px;
    logic [11:0] r_row;
    logic [10:0] r_col;
    logic        r_last, r_eof;

    logic        bot, east, last, advance;
    logic [1:0]  rs [3];
    logic [1:0]  cs [3];
    logic [7:0]  g [3][3];
    logic [11:0] sum;
    logic [24:0] prod;
    logic signed [12:0] acc;
    logic [7:0]  fpx;

    assign bot  = (r_phase == PH_BN) || (r_phase == PH_BE);
    assign east = (r_phase == PH_UE) || (r_phase == PH_BE);

    always_comb begin
        case (r_phase)
            PH_UN: begin
                last    = !(i_job.lc || i_job.lr);
                n_phase = i_job.lc ? PH_UE : (i_job.lr ? PH_BN : PH_UN);
            end
            PH_UE: begin
                last    = !i_job.lr;
                n_phase = i_job.lr ? PH_BN : PH_UN;
            end
            PH_BN: begin
                last    = !i_job.lc;
                n_phase = i_job.lc ? PH_BE : PH_UN;
            end
            default: begin
                last    = 1'b1;
                n_phase = PH_UN;
            end
        endcase
    end

    always_comb begin
        rs[0] = bot ? 2'd1 : (i_job.top ? 2'd2 : 2'd0);
        rs[1] = bot ? 2'd2 : 2'd1;
        rs[2] = bot ? 2'd1 : 2'd2;
        cs[0] = east ? 2'd1 : (i_job.jf ? 2'd2 : 2'd0);
        cs[1] = east ? 2'd2 : 2'd1;
        cs[2] = east ? 2'd1 : 2'd2;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                g[r][c] = i_job.win[rs[r]][cs[c]];
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                sum = sum + 12'(g[r][c]);
            end
        end
        prod = 25'(sum) * 25'(wf3_pkg::RECIP9);
        acc  = '0;
        case (i_mode)
            wf3_pkg::MODE_MEAN: acc = 13'(prod[24:16]);
            wf3_pkg::MODE_LAPLACE:
                acc = 13'(g[0][1]) + 13'(g[2][1]) + 13'(g[1][0]) + 13'(g[1][2])
                      - 13'(g[1][1]) * 13'sd3;
            wf3_pkg::MODE_ROBERTS:
                acc = 13'(g[2][2]) + 13'(g[2][1]) - 13'(g[1][2]);
            wf3_pkg::MODE_SOBEL:
                acc = ((13'(g[1][2]) + 13'(g[2][1]) + 13'(g[2][2]) - 13'(g[0][0])
                       - 13'(g[0][1]) - 13'(g[1][0])) <<< 1) + 13'(g[1][1]);
            default: acc = 13'(g[1][1]);
        endcase
        if (acc < 0)             fpx = 8'd0;
        else if (acc > 13'sd255) fpx = 8'd255;
        else                     fpx = acc[7:0];
    end

    assign advance = i_job_valid && (!r_ov || o_res.ready);
    assign o_pop   = advance && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_UN;
            r_ov    <= 1'b0;
        end else begin
            if (advance) begin
                r_phase <= last ? PH_UN : n_phase;
                r_ov    <= 1'b1;
                r_px    <= fpx;
                r_row   <= bot ? i_job.row : i_job.row - 12'd1;
                r_col   <= east ? i_job.col : i_job.col - 11'd1;
                r_last  <= last;
                r_eof   <= r_phase == PH_BE;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.pixel_out    = r_px;
    assign o_res.out_row      = r_row;
    assign o_res.out_col      = r_col;
    assign o_res.last_in_run  = r_last;
    assign o_res.end_of_frame = r_eof;
endmodule

// ===== design/window_filter_3x3_modes.sv =====
// Top level of the 3x3 window filter: config registers, front, queue, back.
// Path: stage-0 registers, queue, output register. Throughput: one pixel per cycle
// while the queue has room; the back end emits one result per cycle while not stalled,
// so a pixel with 2 or 4 results (last column / last row) holds the queue until all go.
// Reset: synchronous active-low; counters, window and queue clear, config returns
// to 640x480 mean; line stores are not cleared (unwritten entries never reach a result).
module window_filter_3x3_modes #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [wf3_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [wf3_pkg::CFG_W-1:0]  i_cfg_data,
    wf3_px_if.sink                     i_px,
    wf3_res_if.source                  o_res
);
    logic [11:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [2:0]  r_filter_mode;

    logic          push, pop, job_valid;
    wf3_pkg::t_job push_job, head_job;
    logic [wf3_pkg::FIFO_CNT_W-1:0] fifo_count;

    // Config writes; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 12'd640;
            r_frame_height <= 13'd480;
            r_filter_mode  <= wf3_pkg::MODE_MEAN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wf3_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[11:0];
                wf3_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                wf3_pkg::REG_FILTER_MODE:  r_filter_mode  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Front: counts raster position, rotates line stores, builds window jobs
    wf3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_fifo_count   (fifo_count),
        .i_px           (i_px),
        .o_push         (push),
        .o_job          (push_job)
    );

    // Queue decouples pixel intake from multi-result expansion
    wf3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (head_job),
        .o_count (fifo_count)
    );

    // Back: one result per cycle into the output register while the output is not stalled
    wf3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_filter_mode),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_res       (o_res)
    );
endmodule

// ===== design/wf3_checker.sv =====
// Port-level checks for the 3x3 window filter, bound to the top level.
module wf3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_px,
    input logic        out_last,
    input logic        out_eof
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_px))
        else $error("result dropped or changed under stall");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_eof |-> out_last)
        else $error("end of frame without last in run");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result right after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(in_valid && in_ready) && !$past(in_valid && in_ready, 2)
        && !$past(in_valid && in_ready, 3) && !$past(in_valid && in_ready, 4)
        && !$past(out_valid) |-> !out_valid)
        else $error("result without request");
endmodule

bind window_filter_3x3_modes wf3_checker u_wf3_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_px.valid),
    .in_ready  (i_px.ready),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .out_px    (o_res.pixel_out),
    .out_last  (o_res.last_in_run),
    .out_eof   (o_res.end_of_frame)
);
